[design/esc_pkg.sv]
`timescale 1ns / 1ps

package esc_pkg;

	localparam logic [31:0] SHORT_LIMIT = 32'd63072000;
	localparam logic [7:0]  FIRST_YEAR  = 8'd70;
	localparam logic [8:0]  YEAR_DAYS   = 9'd365;
	localparam logic [3:0]  LAST_MONTH  = 4'd11;

	localparam logic [1:0] DIV_SEC  = 2'd0;
	localparam logic [1:0] DIV_MIN  = 2'd1;
	localparam logic [1:0] DIV_HOUR = 2'd2;
	localparam logic [1:0] DIV_DOW  = 2'd3;

	// reciprocals: /60 is >>37 for 32-bit operands, /24 is >>36, /7 is >>20 below 2^17
	localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
	localparam logic [31:0] DIV24_MAGIC = 32'hAAAA_AAAB;
	localparam logic [31:0] DIV7_MAGIC  = 32'd149797;

	localparam logic [9:0] CUM_NORM [12] = '{
		10'd31, 10'd59, 10'd90, 10'd120, 10'd151, 10'd181,
		10'd212, 10'd243, 10'd273, 10'd304, 10'd334, 10'd365
	};
	localparam logic [9:0] CUM_LEAP [12] = '{
		10'd31, 10'd60, 10'd91, 10'd121, 10'd152, 10'd182,
		10'd213, 10'd244, 10'd274, 10'd305, 10'd335, 10'd366
	};

	typedef struct packed {
		logic       load;
		logic       div_load;
		logic       div_end;
		logic [1:0] div_sel;
		logic       year_init;
		logic       year_step;
		logic       mon_init;
		logic       mon_step;
		logic       out_load;
	} esc_cmd_t;

	typedef struct packed {
		logic year_done;
		logic mon_done;
		logic out_free;
	} esc_sts_t;

	function automatic logic [5:0] div_divisor(input logic [1:0] sel);
		logic [5:0] r;
		case (sel)
			DIV_SEC:  r = 6'd60;
			DIV_MIN:  r = 6'd60;
			DIV_HOUR: r = 6'd24;
			DIV_DOW:  r = 6'd7;
			default:  r = 6'd60;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] cum_days(input logic leap, input logic [3:0] idx);
		logic [9:0] r;
		r = 10'd0;
		if (idx <= LAST_MONTH) begin
			r = leap ? CUM_LEAP[idx] : CUM_NORM[idx];
		end
		return r;
	endfunction

endpackage

[design/esc_ctrl.sv]
`timescale 1ns / 1ps

module esc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  esc_pkg::esc_sts_t sts,
	output esc_pkg::esc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DLOAD = 3'd1;
	localparam logic [2:0] ST_DREM  = 3'd2;
	localparam logic [2:0] ST_YEAR  = 3'd3;
	localparam logic [2:0] ST_MON   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.div_sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					sel_d    = esc_pkg::DIV_SEC;
					state_d  = ST_DLOAD;
				end
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DREM;
			end
			ST_DREM: begin
				cmd.div_end = 1'b1;
				if (sel_q == esc_pkg::DIV_DOW) begin
					cmd.year_init = 1'b1;
					state_d       = ST_YEAR;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = ST_DLOAD;
				end
			end
			ST_YEAR: begin
				if (sts.year_done) begin
					cmd.mon_init = 1'b1;
					state_d      = ST_MON;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			ST_MON: begin
				if (sts.mon_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.mon_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= esc_pkg::DIV_SEC;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule

[design/esc_dpath.sv]
`timescale 1ns / 1ps

module esc_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  esc_pkg::esc_cmd_t cmd,
	output esc_pkg::esc_sts_t sts,
	input  logic [31:0]       epoch_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        second_of_minute,
	output logic [5:0]        minute_of_hour,
	output logic [4:0]        hour_of_day,
	output logic [2:0]        day_of_week,
	output logic [7:0]        years_since_1900,
	output logic [9:0]        day_of_year,
	output logic [3:0]        month_index,
	output logic [9:0]        day_of_month
);

	logic [31:0] secs_q;
	logic [31:0] div_q;
	logic [31:0] quo_q;
	logic [5:0]  sec_q, min_q;
	logic [4:0]  hour_q;
	logic [2:0]  dow_q;
	logic [15:0] days_q;
	logic        short_q;
	logic [7:0]  year_q;
	logic [15:0] left_q;
	logic [9:0]  yday_q, mday_q;
	logic [3:0]  mon_q;
	logic        out_valid_q;

	logic [5:0]  divisor;
	logic [31:0] div_src;
	logic [31:0] magic;
	logic [63:0] prod;
	logic [31:0] quo_next;
	logic [11:0] qd_low;
	logic [5:0]  rem;
	logic        leap;
	logic [8:0]  year_len;
	logic [9:0]  cum_cur, cum_next;

	// quotient by reciprocal multiplication on load, remainder the cycle after;
	// the remainder is below 64, so the low six bits are enough
	always_comb begin
		divisor = esc_pkg::div_divisor(cmd.div_sel);
		case (cmd.div_sel)
			esc_pkg::DIV_SEC: div_src = secs_q;
			esc_pkg::DIV_DOW: div_src = {16'd0, days_q + 16'd4};
			default:          div_src = quo_q;
		endcase
		case (cmd.div_sel)
			esc_pkg::DIV_HOUR: magic = esc_pkg::DIV24_MAGIC;
			esc_pkg::DIV_DOW:  magic = esc_pkg::DIV7_MAGIC;
			default:           magic = esc_pkg::DIV60_MAGIC;
		endcase
		prod = {32'd0, div_src} * {32'd0, magic};
		case (cmd.div_sel)
			esc_pkg::DIV_HOUR: quo_next = {4'd0, prod[63:36]};
			esc_pkg::DIV_DOW:  quo_next = prod[51:20];
			default:           quo_next = {5'd0, prod[63:37]};
		endcase
		qd_low = {6'd0, quo_q[5:0]} * {6'd0, divisor};
		rem    = div_q[5:0] - qd_low[5:0];
	end

	assign leap     = !short_q && (year_q[1:0] == 2'b00);
	assign year_len = esc_pkg::YEAR_DAYS + {8'd0, leap};
	assign cum_cur  = esc_pkg::cum_days(leap, mon_q);
	assign cum_next = esc_pkg::cum_days(leap, mon_q + 4'd1);

	assign sts.year_done = short_q || (left_q < {7'd0, year_len});
	assign sts.mon_done  = (mon_q == esc_pkg::LAST_MONTH) || (yday_q <= cum_cur);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			secs_q <= epoch_seconds;
		end
		if (cmd.div_load) begin
			div_q <= div_src;
			quo_q <= quo_next;
		end
		if (cmd.div_end) begin
			case (cmd.div_sel)
				esc_pkg::DIV_SEC: sec_q <= rem;
				esc_pkg::DIV_MIN: min_q <= rem;
				esc_pkg::DIV_HOUR: begin
					hour_q <= rem[4:0];
					days_q <= quo_q[15:0];
				end
				esc_pkg::DIV_DOW: dow_q <= rem[2:0];
				default: sec_q <= rem;
			endcase
		end
		if (cmd.year_init) begin
			short_q <= (secs_q <= esc_pkg::SHORT_LIMIT);
			year_q  <= (secs_q <= esc_pkg::SHORT_LIMIT) ? 8'd0 : esc_pkg::FIRST_YEAR;
			left_q  <= days_q;
		end else if (cmd.year_step) begin
			left_q <= left_q - {7'd0, year_len};
			year_q <= year_q + 8'd1;
		end
		if (cmd.mon_init) begin
			yday_q <= left_q[9:0] + 10'd1;
			mday_q <= left_q[9:0] + 10'd1;
			mon_q  <= 4'd0;
		end else if (cmd.mon_step) begin
			if (yday_q <= cum_next) begin
				mday_q <= yday_q - cum_cur;
			end
			mon_q <= mon_q + 4'd1;
		end
		if (cmd.out_load) begin
			second_of_minute <= sec_q;
			minute_of_hour   <= min_q;
			hour_of_day      <= hour_q;
			day_of_week      <= dow_q;
			years_since_1900 <= year_q;
			day_of_year      <= yday_q;
			month_index      <= mon_q;
			day_of_month     <= mday_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[design/epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 1ps

// Epoch seconds to calendar fields.
// Input channel: in_valid / in_ready with epoch_seconds. Output channel:
// out_valid / out_ready with the eight calendar fields of one result item.
// One result item per input item, in order.
// From acceptance to out_valid: the chain /60, /60, /24 and the weekday mod 7
// uses reciprocal multiplication, each division registering its quotient and
// then its remainder; then the year walk removes one year of days per cycle
// (up to 136 years), then the month search moves one month per cycle (up to
// 11), and the result is loaded into the output register. The next item is
// accepted once that load has returned the core to idle; in_ready is high
// only while the core is idle.
// The result sits in an output register, so the core takes the next item
// while a finished result still waits; if the receiver stalls, the core
// holds its next result internally until the register frees up.
// Reset clears the controller and the output valid flag; no clearing pass.

module epoch_seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [2:0]  day_of_week,
	output logic [7:0]  years_since_1900,
	output logic [9:0]  day_of_year,
	output logic [3:0]  month_index,
	output logic [9:0]  day_of_month
);

	esc_pkg::esc_cmd_t cmd;
	esc_pkg::esc_sts_t sts;

	esc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	esc_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_week      (day_of_week),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("core accepted an item while busy");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> second_of_minute < 6'd60 && minute_of_hour < 6'd60
			&& hour_of_day < 5'd24 && day_of_week < 3'd7)
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month_index <= 4'd11 && day_of_month != 10'd0
			&& day_of_month <= day_of_year)
		else $error("date fields inconsistent");

	a_year_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && years_since_1900 == 8'd0 |-> day_of_year <= 10'd731)
		else $error("short count day number out of range");

endmodule

[tb/sv/calendar_checker.sv]
`timescale 1ns / 1ps

module calendar_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] epoch_seconds,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  second_of_minute,
	input  logic [5:0]  minute_of_hour,
	input  logic [4:0]  hour_of_day,
	input  logic [2:0]  day_of_week,
	input  logic [7:0]  years_since_1900,
	input  logic [9:0]  day_of_year,
	input  logic [3:0]  month_index,
	input  logic [9:0]  day_of_month,
	output int          fail_count,
	output int          awaiting
);

	localparam logic [31:0] DAY_SECONDS   = 32'd86400;
	localparam logic [31:0] TWO_YEAR_SECS = 32'd63072000;
	localparam logic [7:0]  EPOCH_YEAR    = 8'd70;
	localparam logic [3:0]  DECEMBER      = 4'd11;
	localparam int          PRINT_CAP     = 50;

	localparam logic [9:0] NORMAL_ENDS [12] = '{
		10'd31, 10'd59, 10'd90, 10'd120, 10'd151, 10'd181,
		10'd212, 10'd243, 10'd273, 10'd304, 10'd334, 10'd365
	};
	localparam logic [9:0] LEAP_ENDS [12] = '{
		10'd31, 10'd60, 10'd91, 10'd121, 10'd152, 10'd182,
		10'd213, 10'd244, 10'd274, 10'd305, 10'd335, 10'd366
	};

	typedef struct {
		logic [31:0] secs;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [2:0]  wday;
		logic [7:0]  year;
		logic [9:0]  yday;
		logic [3:0]  mon;
		logic [9:0]  mday;
	} calendar_t;

	calendar_t calendar_q[$];

	initial begin
		fail_count = 0;
		awaiting   = 0;
	end

	function automatic logic [9:0] month_end(input logic leap, input logic [3:0] idx);
		return leap ? LEAP_ENDS[idx] : NORMAL_ENDS[idx];
	endfunction

	function automatic calendar_t calendar_of(input logic [31:0] secs);
		calendar_t   c;
		logic [31:0] days;
		logic [31:0] left;
		logic [7:0]  yr;
		logic        leap;
		logic [9:0]  yday;
		logic [9:0]  mday;
		logic [3:0]  mon;
		days = secs / DAY_SECONDS;
		left = days;
		yr   = 8'd0;
		leap = 1'b0;
		if (secs > TWO_YEAR_SECS) begin
			yr   = EPOCH_YEAR;
			leap = (yr[1:0] == 2'd0);
			while (left >= 32'd365 + 32'(leap)) begin
				left = left - (32'd365 + 32'(leap));
				yr   = yr + 8'd1;
				leap = (yr[1:0] == 2'd0);
			end
		end
		yday = left[9:0] + 10'd1;
		mday = yday;
		mon  = 4'd0;
		while (mon < DECEMBER && yday > month_end(leap, mon)) begin
			if (yday <= month_end(leap, mon + 4'd1))
				mday = yday - month_end(leap, mon);
			mon = mon + 4'd1;
		end
		c.secs = secs;
		c.sec  = 6'(secs % 32'd60);
		c.min  = 6'((secs / 32'd60) % 32'd60);
		c.hour = 5'((secs / 32'd3600) % 32'd24);
		c.wday = 3'((days + 32'd4) % 32'd7);
		c.year = yr;
		c.yday = yday;
		c.mon  = mon;
		c.mday = mday;
		return c;
	endfunction

	task automatic report(input string what, input logic [31:0] secs,
			input longint got, input longint want);
		if (fail_count < PRINT_CAP)
			$display("tb: mismatch %s for %0d s: got %0d, expected %0d",
				what, secs, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		calendar_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (calendar_q.size() == 0) begin
					report("unexpected item", 32'd0, 0, 0);
				end else begin
					want = calendar_q.pop_front();
					if (second_of_minute !== want.sec)
						report("second", want.secs, second_of_minute, want.sec);
					if (minute_of_hour !== want.min)
						report("minute", want.secs, minute_of_hour, want.min);
					if (hour_of_day !== want.hour)
						report("hour", want.secs, hour_of_day, want.hour);
					if (day_of_week !== want.wday)
						report("weekday", want.secs, day_of_week, want.wday);
					if (years_since_1900 !== want.year)
						report("year", want.secs, years_since_1900, want.year);
					if (day_of_year !== want.yday)
						report("day of year", want.secs, day_of_year, want.yday);
					if (month_index !== want.mon)
						report("month", want.secs, month_index, want.mon);
					if (day_of_month !== want.mday)
						report("day of month", want.secs, day_of_month, want.mday);
				end
			end
			if (in_valid && in_ready)
				calendar_q.push_back(calendar_of(epoch_seconds));
			awaiting <= calendar_q.size();
		end
	end

endmodule

[tb/sv/tb_epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_core;

	localparam int          RANDOM_ITEMS  = 400;
	localparam int          CALM_FIRST    = 200;
	localparam int          CALM_LAST     = 300;
	localparam int          IDLE_PERCENT  = 6;
	localparam int          DRAIN_CYCLES  = 400;
	localparam int          CYCLE_LIMIT   = 1000000;
	localparam logic [31:0] DAY_SECONDS   = 32'd86400;
	localparam logic [31:0] TWO_YEAR_SECS = 32'd63072000;
	localparam int          DIRECTED_COUNT = 24;

	localparam logic [31:0] DIRECTED [DIRECTED_COUNT] = '{
		32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
		32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
		32'd63071999, TWO_YEAR_SECS, TWO_YEAR_SECS + 32'd1,
		32'd68169600, 32'd94607999, 32'd94608000,
		32'd951782400, 32'd4107542400, 32'd4107542399,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
		32'hFFFF_FFFF
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [31:0] epoch_seconds = 32'd0;
	logic        out_ready = 1'b0;
	logic        calm      = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [2:0]  day_of_week;
	logic [7:0]  years_since_1900;
	logic [9:0]  day_of_year;
	logic [3:0]  month_index;
	logic [9:0]  day_of_month;
	int          fail_count;
	int          awaiting;
	int          cycles = 0;

	epoch_seconds_to_calendar_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_week      (day_of_week),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month)
	);

	calendar_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_week      (day_of_week),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month),
		.fail_count       (fail_count),
		.awaiting         (awaiting)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
	end

	task automatic send_seconds(input logic [31:0] secs);
		while (!calm && $urandom_range(99) < IDLE_PERCENT)
			@(posedge clk);
		@(posedge clk);
		in_valid      <= 1'b1;
		epoch_seconds <= secs;
		do
			@(posedge clk);
		while (!in_ready);
		in_valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_seconds();
		int          pick;
		logic [31:0] day;
		pick = $urandom_range(99);
		if (pick < 40)
			return $urandom;
		if (pick < 60)
			return $urandom_range(2 * TWO_YEAR_SECS);
		if (pick < 80) begin
			day = $urandom_range(49709);
			case ($urandom_range(2))
				0:       return day * DAY_SECONDS;
				1:       return day * DAY_SECONDS + DAY_SECONDS - 32'd1;
				default: return day * DAY_SECONDS + $urandom_range(86399);
			endcase
		end
		if (pick < 90)
			return TWO_YEAR_SECS - 32'd200000 + $urandom_range(400000);
		return 32'hF000_0000 | 32'($urandom_range(32'h0FFF_FFFF));
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_seconds(DIRECTED[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == CALM_FIRST)
				calm <= 1'b1;
			if (n == CALM_LAST)
				calm <= 1'b0;
			send_seconds(random_seconds());
		end
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
